FILE: rtl/skin_weight_packer_macros.svh
// assertion macros for the skin weight packer
`ifndef SKIN_WEIGHT_PACKER_MACROS_SVH
`define SKIN_WEIGHT_PACKER_MACROS_SVH
`ifndef SYNTH
`define SWP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define SWP_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SWP_ASSERT(label, clk, rst, prop)
`define SWP_ASSERT_RST(label, clk, prop)
`endif
`endif

FILE: rtl/swp_pkg.sv
// shared types and constants for the skin weight packer
package swp_pkg;
  localparam int VertexCountDefault = 4096;
  localparam int BoneCountDefault = 256;
  localparam int Slots = 4;
  localparam int VtxW = 12;
  localparam int BoneW = 8;
  localparam int WgtW = 16;
  localparam int CntW = 3;
  localparam int TotW = 18;
  localparam int DivSteps = 32;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_DIV,
    ST_OUT
  } state_t;

  // per vertex record: count, drop, four bones, four weights
  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic drop;
    logic [Slots-1:0][BoneW-1:0] bone;
    logic [Slots-1:0][WgtW-1:0] wgt;
  } vrec_t;

  localparam int RecW = $bits(vrec_t);
endpackage

FILE: rtl/swp_ram.sv
// generic single port ram with registered read
module swp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0] wdata,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

FILE: rtl/skin_weight_packer.sv
// skin weight packer top level
// usage:
// - input channel (valid/ready) carries command, vertex_index, bone_index, weight
// - output channel (out_valid/out_ready) carries one result per read command
// - each vertex record (count, drop flag, four bones, four weights) is one ram word
// - after reset a clearing pass writes every record to zero, one per cycle,
//   during which ready stays low
// - add and clear: accept with ram read, then write back
// - a read runs a shared restoring divider that produces one
//   quotient bit per cycle for each of the four slots in turn
// - the result sits in an output register; while the receiver stalls the block
//   holds it and accepts no new item until it is taken
// - one item is in flight at a time, so no read can see a stale record
`include "skin_weight_packer_macros.svh"
module skin_weight_packer import swp_pkg::*; #(
  parameter int VERTEX_COUNT = VertexCountDefault,
  parameter int BONE_COUNT = BoneCountDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic ready,
  input  logic [1:0] command,
  input  logic [VtxW-1:0] vertex_index,
  input  logic [BoneW-1:0] bone_index,
  input  logic [WgtW-1:0] weight,
  output logic out_valid,
  input  logic out_ready,
  output logic [VtxW-1:0] vertex_out,
  output logic [BoneW-1:0] bone_id_0,
  output logic [BoneW-1:0] bone_id_1,
  output logic [BoneW-1:0] bone_id_2,
  output logic [BoneW-1:0] bone_id_3,
  output logic [WgtW-1:0] norm_weight_0,
  output logic [WgtW-1:0] norm_weight_1,
  output logic [WgtW-1:0] norm_weight_2,
  output logic [WgtW-1:0] norm_weight_3,
  output logic [CntW-1:0] slots_used,
  output logic dropped
);
  localparam int AddrW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int ClrW = AddrW + 1;
  localparam int StepW = $clog2(DivSteps);

  state_t state, state_next;
  logic [ClrW-1:0] clr_cnt;
  cmd_t cmd;
  logic [VtxW-1:0] vtx;
  logic [BoneW-1:0] bone;
  logic [WgtW-1:0] wgt;
  logic inrange;
  vrec_t rec;
  vrec_t rdata, wdata;
  logic we;
  logic [AddrW-1:0] addr;
  logic [1:0] slot;
  logic [StepW-1:0] step;
  logic [TotW-1:0] total;
  logic [TotW-1:0] rem;
  logic [DivSteps-1:0] dvd;
  logic [DivSteps-2:0] quo;
  logic [TotW:0] rem_sh;
  logic [TotW:0] rem_sub;
  logic [Slots-1:0][WgtW-1:0] nw;
  logic accept;

  assign ready = (state == ST_IDLE);
  assign accept = valid && ready;

  swp_ram #(.Width(RecW), .Depth(VERTEX_COUNT)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_comb begin
    addr = AddrW'(vtx);
    if (state == ST_CLEAR) addr = clr_cnt[AddrW-1:0];
    else if (accept) addr = AddrW'(vertex_index);
  end

  // write back on the look cycle for add and clear, and zero records during the clearing pass
  always_comb begin
    we = 1'b0;
    wdata = rdata;
    if (state == ST_CLEAR) begin
      we = 1'b1;
      wdata = '0;
    end else if (state == ST_LOOK && inrange) begin
      if (cmd == CMD_CLEAR) begin
        we = 1'b1;
        wdata = '0;
      end else if (cmd == CMD_ADD && {8'd0, bone} < BONE_COUNT) begin
        we = 1'b1;
        if (rdata.cnt >= CntW'(Slots)) begin
          wdata.drop = 1'b1;
        end else begin
          wdata.bone[rdata.cnt[1:0]] = bone;
          wdata.wgt[rdata.cnt[1:0]] = wgt;
          wdata.cnt = rdata.cnt + CntW'(1);
        end
      end
    end
  end

  // one restoring division step: (w << 16) / total
  assign rem_sh = {rem, dvd[DivSteps-1]};
  assign rem_sub = rem_sh - {1'b0, total};

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == ClrW'(VERTEX_COUNT - 1)) state_next = ST_IDLE;
      ST_IDLE: if (accept) state_next = ST_LOOK;
      ST_LOOK: begin
        if (cmd == CMD_READ) state_next = inrange ? ST_DIV : ST_OUT;
        else state_next = ST_IDLE;
      end
      ST_DIV: if (step == StepW'(DivSteps - 1) && slot == 2'd3) state_next = ST_OUT;
      ST_OUT: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + ClrW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_t'(command);
      vtx <= vertex_index;
      bone <= bone_index;
      wgt <= weight;
      inrange <= {8'd0, vertex_index} < VERTEX_COUNT;
    end
    if (state == ST_LOOK) begin
      rec <= inrange ? rdata : '0;
      total <= TotW'(rdata.wgt[0]) + TotW'(rdata.wgt[1])
             + TotW'(rdata.wgt[2]) + TotW'(rdata.wgt[3]);
      slot <= 2'd0;
      step <= '0;
      rem <= '0;
      dvd <= {rdata.wgt[0], 16'd0};
      nw <= '0;
    end else if (state == ST_DIV) begin
      quo <= {quo[DivSteps-3:0], ~rem_sub[TotW]};
      step <= step + StepW'(1);
      if (step == StepW'(DivSteps - 1)) begin
        // final quotient bit is ~rem_sub sign
        if (total == '0) nw[slot] <= '0;
        else if (quo[DivSteps-2:WgtW-1] != '0) nw[slot] <= '1;
        else nw[slot] <= {quo[WgtW-2:0], ~rem_sub[TotW]};
        slot <= slot + 2'd1;
        rem <= '0;
        dvd <= {rec.wgt[slot + 2'd1], 16'd0};
      end else begin
        rem <= rem_sub[TotW] ? rem_sh[TotW-1:0] : rem_sub[TotW-1:0];
        dvd <= {dvd[DivSteps-2:0], 1'b0};
      end
    end
  end

  assign out_valid = (state == ST_OUT);
  assign vertex_out = vtx;
  assign bone_id_0 = rec.bone[0];
  assign bone_id_1 = rec.bone[1];
  assign bone_id_2 = rec.bone[2];
  assign bone_id_3 = rec.bone[3];
  assign norm_weight_0 = nw[0];
  assign norm_weight_1 = nw[1];
  assign norm_weight_2 = nw[2];
  assign norm_weight_3 = nw[3];
  assign slots_used = rec.cnt;
  assign dropped = rec.drop;

  `SWP_ASSERT(a_no_accept_busy, clk, rst, (state != ST_IDLE) |-> !ready)
  `SWP_ASSERT(a_out_hold, clk, rst, (out_valid && !out_ready) |=> out_valid)
  `SWP_ASSERT(a_cnt_max, clk, rst, (state == ST_OUT) |-> (slots_used <= CntW'(Slots)))
  `SWP_ASSERT(a_no_write_div, clk, rst, (state == ST_DIV || state == ST_OUT) |-> !we)
endmodule
